// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file of the range display.
// No dependencies; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define URD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define URD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/urd_pkg.sv =====
// Types, codes, constants and lookup functions of the ultrasonic range display.
// No dependencies; used by every module of the block.
package urd_pkg;

  // Default parameter values
  localparam int NUM_DIGITS_DEF = 4;
  localparam int LOCKOUT_MS_DEF = 200;

  // Field widths
  localparam int REQ_W     = 2;
  localparam int ECHO_W    = 16;
  localparam int CM_W      = 14;
  localparam int SCALE_W   = 11;
  localparam int PROD_W    = ECHO_W + SCALE_W;
  localparam int CMP_W     = CM_W + 16;
  localparam int SEG_W     = 7;
  localparam int DSEL_W    = 4;
  localparam int LED_W     = 3;
  localparam int ZONE_W    = 2;
  localparam int HZ_W      = 10;
  localparam int DIGIT_W   = 4;
  localparam int LOCK_W    = 8;
  localparam int CFG_IDX_W = 2;

  // Decimal digits a saturated distance can have
  localparam int MEAS_DIGITS = 4;

  // Q16 scale: cm = echo_us * 1129 >> 16
  localparam logic [SCALE_W-1:0] CM_SCALE_Q16 = 11'd1129;
  localparam logic [CM_W-1:0]    MAX_CM       = 14'd9999;
  localparam logic [LOCK_W-1:0]  LOCK_SAT     = 8'd255;

  // Exact reciprocals for values below 16384
  localparam logic [15:0] RECIP10   = 16'd52429;  // >> 19
  localparam logic [15:0] RECIP100  = 16'd5243;   // >> 19
  localparam logic [15:0] RECIP1000 = 16'd8389;   // >> 23

  // Threshold reset values
  localparam logic [CM_W-1:0] FAR_RST  = 14'd60;
  localparam logic [CM_W-1:0] MID_RST  = 14'd30;
  localparam logic [CM_W-1:0] NEAR_RST = 14'd15;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_MEASURE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SCAN    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_BUTTON  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_MS_TICK = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FAR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR = 2'd2;

  // Zone codes
  localparam logic [ZONE_W-1:0] ZONE_FAR  = 2'd0;
  localparam logic [ZONE_W-1:0] ZONE_MID  = 2'd1;
  localparam logic [ZONE_W-1:0] ZONE_NEAR = 2'd2;
  localparam logic [ZONE_W-1:0] ZONE_CRIT = 2'd3;

  // LED line codes
  localparam logic [LED_W-1:0] LED_GREEN  = 3'b001;
  localparam logic [LED_W-1:0] LED_YELLOW = 3'b010;
  localparam logic [LED_W-1:0] LED_RED    = 3'b100;

  localparam logic [SEG_W-1:0] SEG_BLANK_N = 7'h7F;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [ECHO_W-1:0] echo_us;
  } in_item_t;

  typedef struct packed {
    logic [SEG_W-1:0]  segments_n;
    logic [DSEL_W-1:0] digit_enable;
    logic [LED_W-1:0]  led_lines;
    logic [ZONE_W-1:0] zone;
    logic              tone_start;
    logic [HZ_W-1:0]   tone_hz;
    logic [CM_W-1:0]   distance_cm;
    logic              enabled;
  } out_item_t;

  // Converted measurement; digits[0] is the units digit
  typedef struct packed {
    logic [CM_W-1:0]                         cm;
    logic [ZONE_W-1:0]                       zone;
    logic [MEAS_DIGITS-1:0][DIGIT_W-1:0]     digits;
  } meas_t;

  // Active-low segments a..g for one digit, blank above nine
  function automatic logic [SEG_W-1:0] seg_n(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] on;
    unique case (d)
      4'd0:    on = 7'h3F;
      4'd1:    on = 7'h06;
      4'd2:    on = 7'h5B;
      4'd3:    on = 7'h4F;
      4'd4:    on = 7'h66;
      4'd5:    on = 7'h6D;
      4'd6:    on = 7'h7D;
      4'd7:    on = 7'h07;
      4'd8:    on = 7'h7F;
      4'd9:    on = 7'h6F;
      default: on = 7'h00;
    endcase
    return ~on;
  endfunction

  function automatic logic [HZ_W-1:0] zone_tone(input logic [ZONE_W-1:0] z);
    logic [HZ_W-1:0] hz;
    unique case (z)
      ZONE_FAR:  hz = 10'd150;
      ZONE_MID:  hz = 10'd300;
      ZONE_NEAR: hz = 10'd400;
      default:   hz = 10'd523;
    endcase
    return hz;
  endfunction

  function automatic logic [LED_W-1:0] zone_led(input logic [ZONE_W-1:0] z);
    logic [LED_W-1:0] led;
    unique case (z)
      ZONE_FAR: led = LED_GREEN;
      ZONE_MID: led = LED_YELLOW;
      default:  led = LED_RED;
    endcase
    return led;
  endfunction

endpackage

// ===== hdl/urd_scale.sv =====
// Measurement conversion: registered Q16 product to saturated cm, zone, digits.
// Depends on urd_pkg.
module urd_scale (
  input  logic [urd_pkg::PROD_W-1:0] prod,
  input  logic [urd_pkg::CM_W-1:0]   far_thr,
  input  logic [urd_pkg::CM_W-1:0]   mid_thr,
  input  logic [urd_pkg::CM_W-1:0]   near_thr,
  output urd_pkg::meas_t             meas
);

  logic [urd_pkg::PROD_W-16-1:0] cm_raw;
  logic [urd_pkg::CM_W-1:0]      cm;
  logic [urd_pkg::CMP_W-1:0]     prod_x;
  logic [29:0]                   m10, m100, m1000;
  logic [10:0]                   q1;
  logic [10:0]                   q2;
  logic [6:0]                    q3;

  // Truncate to whole centimetres and saturate
  assign cm_raw = prod[urd_pkg::PROD_W-1:16];
  always_comb begin
    if (urd_pkg::CM_W'(cm_raw) > urd_pkg::MAX_CM) begin
      cm = urd_pkg::MAX_CM;
    end else begin
      cm = urd_pkg::CM_W'(cm_raw);
    end
  end

  // Classify the full-precision product, strictly greater than
  assign prod_x = urd_pkg::CMP_W'(prod);
  always_comb begin
    priority if (prod_x > {far_thr, 16'b0}) begin
      meas.zone = urd_pkg::ZONE_FAR;
    end else if (prod_x > {mid_thr, 16'b0}) begin
      meas.zone = urd_pkg::ZONE_MID;
    end else if (prod_x > {near_thr, 16'b0}) begin
      meas.zone = urd_pkg::ZONE_NEAR;
    end else begin
      meas.zone = urd_pkg::ZONE_CRIT;
    end
  end

  // Quotients by 10, 100, 1000 through reciprocal multiplies
  assign m10   = 30'(cm) * 30'(urd_pkg::RECIP10);
  assign m100  = 30'(cm) * 30'(urd_pkg::RECIP100);
  assign m1000 = 30'(cm) * 30'(urd_pkg::RECIP1000);
  assign q1    = m10[29:19];
  assign q2    = m100[29:19];
  assign q3    = m1000[29:23];

  // Remainders: value minus ten times the next quotient (shift-add)
  assign meas.cm        = cm;
  assign meas.digits[0] = urd_pkg::DIGIT_W'(cm - (urd_pkg::CM_W'({q1, 3'b0})
                                               + urd_pkg::CM_W'({q1, 1'b0})));
  assign meas.digits[1] = urd_pkg::DIGIT_W'(q1 - (11'({q2, 3'b0}) + 11'({q2, 1'b0})));
  assign meas.digits[2] = urd_pkg::DIGIT_W'(q2 - (11'({q3, 3'b0}) + 11'({q3, 1'b0})));
  assign meas.digits[3] = urd_pkg::DIGIT_W'(q3);

endmodule

// ===== hdl/urd_seg.sv =====
// Display driver for one scan step: segment pattern and one-hot digit select.
// Depends on urd_pkg.
module urd_seg #(
  parameter int NUM_DIGITS = urd_pkg::NUM_DIGITS_DEF,
  parameter int POS_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1
) (
  input  logic [NUM_DIGITS-1:0][urd_pkg::DIGIT_W-1:0] digits,
  input  logic [POS_W-1:0]                            pos,
  output logic [urd_pkg::SEG_W-1:0]                   segments_n,
  output logic [urd_pkg::DSEL_W-1:0]                  digit_enable
);

  // Look up the stored digit at the scan position
  assign segments_n = urd_pkg::seg_n(digits[pos]);

  // Select only the first four digit lines
  always_comb begin
    for (int k = 0; k < urd_pkg::DSEL_W; k++) begin
      digit_enable[k] = (32'(pos) == k);
    end
  end

endmodule

// ===== hdl/ultrasonic_range_display.sv =====
// Ultrasonic range display, top level.
// Each item passes through the input, product and result registers before its result is valid.
// Throughput: one item per cycle unless the output stalls; state commits as each item enters the result register.
// Stalls propagate back through the three stages by their valid bits.
// Reset (rst_n low, synchronous) empties the pipeline and restores thresholds 60/30/15,
// digits 0, scan position 0, enable 1, lockout 255, zone far and distance 0.
module ultrasonic_range_display #(
  parameter int NUM_DIGITS = urd_pkg::NUM_DIGITS_DEF,
  parameter int LOCKOUT_MS = urd_pkg::LOCKOUT_MS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  urd_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output urd_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [urd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [urd_pkg::CM_W-1:0]      cfg_data
);

  localparam int POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  // Pipeline registers
  logic                          v1_r, v2_r, out_valid_r;
  urd_pkg::in_item_t             in_r;
  logic [urd_pkg::REQ_W-1:0]     req2_r;
  logic [urd_pkg::PROD_W-1:0]    prod2_r;
  urd_pkg::out_item_t            out_r, out_nxt;
  logic                          out_adv, s2_free, adv1, adv2;

  // Configuration registers
  logic [urd_pkg::CM_W-1:0]      far_thr_r, mid_thr_r, near_thr_r;

  // Block state
  logic [NUM_DIGITS-1:0][urd_pkg::DIGIT_W-1:0] digit_r, digit_nxt, store_val;
  logic [POS_W-1:0]              pos_r, pos_nxt;
  logic                          enable_r, enable_nxt;
  logic [urd_pkg::LOCK_W-1:0]    lock_r, lock_nxt;
  logic [urd_pkg::ZONE_W-1:0]    zone_r, zone_nxt;
  logic [urd_pkg::CM_W-1:0]      dist_r, dist_nxt;

  urd_pkg::meas_t                meas;
  logic [urd_pkg::SEG_W-1:0]     scan_seg_n;
  logic [urd_pkg::DSEL_W-1:0]    scan_dsel;

  // Handshake chain
  assign out_adv   = !out_valid_r || out_ready;
  assign adv2      = v2_r && out_adv;
  assign s2_free   = !v2_r || out_adv;
  assign adv1      = v1_r && s2_free;
  assign in_ready  = !v1_r || s2_free;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        v1_r <= in_valid;
      end
      if (s2_free) begin
        v2_r <= v1_r;
      end
      if (out_adv) begin
        out_valid_r <= v2_r;
      end
    end
  end

  // Payload stages: capture, scale the echo, then register the result
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (adv1) begin
      req2_r  <= in_r.req_type;
      prod2_r <= urd_pkg::PROD_W'(in_r.echo_us) * urd_pkg::PROD_W'(urd_pkg::CM_SCALE_Q16);
    end
    if (adv2) begin
      out_r <= out_nxt;
    end
  end

  // Threshold writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      far_thr_r  <= urd_pkg::FAR_RST;
      mid_thr_r  <= urd_pkg::MID_RST;
      near_thr_r <= urd_pkg::NEAR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        urd_pkg::CFG_FAR:  far_thr_r  <= cfg_data;
        urd_pkg::CFG_MID:  mid_thr_r  <= cfg_data;
        urd_pkg::CFG_NEAR: near_thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  urd_scale u_scale (
    .prod     (prod2_r),
    .far_thr  (far_thr_r),
    .mid_thr  (mid_thr_r),
    .near_thr (near_thr_r),
    .meas     (meas)
  );

  urd_seg #(
    .NUM_DIGITS (NUM_DIGITS),
    .POS_W      (POS_W)
  ) u_seg (
    .digits       (digit_r),
    .pos          (pos_r),
    .segments_n   (scan_seg_n),
    .digit_enable (scan_dsel)
  );

  // Map decimal digits onto display positions, leftmost first
  for (genvar p = 0; p < NUM_DIGITS; p++) begin : g_store
    if (NUM_DIGITS - 1 - p < urd_pkg::MEAS_DIGITS) begin : g_dig
      assign store_val[p] = meas.digits[NUM_DIGITS - 1 - p];
    end else begin : g_zero
      assign store_val[p] = '0;
    end
  end

  // Commit one request to state and build its result
  always_comb begin
    digit_nxt  = digit_r;
    pos_nxt    = pos_r;
    enable_nxt = enable_r;
    lock_nxt   = lock_r;
    zone_nxt   = zone_r;
    dist_nxt   = dist_r;

    out_nxt.segments_n   = urd_pkg::SEG_BLANK_N;
    out_nxt.digit_enable = '0;
    out_nxt.tone_start   = 1'b0;

    unique case (req2_r)
      urd_pkg::REQ_MEASURE: begin
        if (enable_r) begin
          digit_nxt          = store_val;
          zone_nxt           = meas.zone;
          dist_nxt           = meas.cm;
          out_nxt.tone_start = 1'b1;
        end
      end
      urd_pkg::REQ_SCAN: begin
        out_nxt.segments_n   = scan_seg_n;
        out_nxt.digit_enable = scan_dsel;
        pos_nxt = (pos_r == POS_W'(NUM_DIGITS - 1)) ? '0 : pos_r + 1'b1;
      end
      urd_pkg::REQ_BUTTON: begin
        if (lock_r > urd_pkg::LOCK_W'(LOCKOUT_MS)) begin
          enable_nxt = !enable_r;
          lock_nxt   = '0;
        end
      end
      default: begin
        if (lock_r != urd_pkg::LOCK_SAT) begin
          lock_nxt = lock_r + 1'b1;
        end
      end
    endcase

    out_nxt.tone_hz     = out_nxt.tone_start ? urd_pkg::zone_tone(zone_nxt) : '0;
    out_nxt.led_lines   = urd_pkg::zone_led(zone_nxt);
    out_nxt.zone        = zone_nxt;
    out_nxt.distance_cm = dist_nxt;
    out_nxt.enabled     = enable_nxt;
  end

  // State registers advance as a result is produced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r  <= '0;
      pos_r    <= '0;
      enable_r <= 1'b1;
      lock_r   <= urd_pkg::LOCK_SAT;
      zone_r   <= urd_pkg::ZONE_FAR;
      dist_r   <= '0;
    end else if (adv2) begin
      digit_r  <= digit_nxt;
      pos_r    <= pos_nxt;
      enable_r <= enable_nxt;
      lock_r   <= lock_nxt;
      zone_r   <= zone_nxt;
      dist_r   <= dist_nxt;
    end
  end

endmodule

// ===== hdl/urd_checker.sv =====
// Port-level checker for the ultrasonic range display, bound to the top level.
// Depends on urd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module urd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input urd_pkg::out_item_t out_data
);

  // Hold a stalled result
  `URD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

  // A scan result drives exactly one digit and starts no tone
  `URD_ASSERT_IMP(a_scan_onehot, clk, rst_n, out_valid && (out_data.digit_enable != 4'd0), $onehot(out_data.digit_enable) && !out_data.tone_start, "bad scan result")

  // A tone starts only while enabled, with a nonzero frequency
  `URD_ASSERT_IMP(a_tone_enabled, clk, rst_n, out_valid && out_data.tone_start, out_data.enabled && (out_data.tone_hz != 10'd0), "tone while disabled")

  // LED lines follow the zone
  `URD_ASSERT_IMP(a_led_zone, clk, rst_n, out_valid, ((out_data.zone == urd_pkg::ZONE_FAR) && (out_data.led_lines == urd_pkg::LED_GREEN)) || ((out_data.zone == urd_pkg::ZONE_MID) && (out_data.led_lines == urd_pkg::LED_YELLOW)) || ((out_data.zone != urd_pkg::ZONE_FAR) && (out_data.zone != urd_pkg::ZONE_MID) && (out_data.led_lines == urd_pkg::LED_RED)), "LED lines disagree with zone")

endmodule

bind ultrasonic_range_display urd_checker u_urd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== verif/tb_ultrasonic_range_display.sv =====
// Self-checking testbench for ultrasonic_range_display: predicts every result from a
// shadow of the display state and compares each output transfer field by field.
// Depends on urd_pkg (types, codes, reset values) and the ultrasonic_range_display RTL.
module tb_ultrasonic_range_display;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF     = 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 38;
  localparam int NUM_PHASES   = 6;
  localparam int SCAN_DIGITS  = 4;
  localparam int MAX_PRINTED  = 50;
  // Index past the last threshold register; writes to it must change nothing
  localparam logic [urd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [urd_pkg::CM_W-1:0]      THR_TOP   = 14'h3FFF;
  localparam logic [urd_pkg::ECHO_W-1:0]    ECHO_TOP  = 16'hFFFF;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  urd_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  urd_pkg::out_item_t out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [urd_pkg::CFG_IDX_W-1:0] cfg_index = urd_pkg::CFG_FAR;
  logic [urd_pkg::CM_W-1:0]      cfg_data = '0;

  // Shadow of the display state and thresholds
  logic [urd_pkg::CM_W-1:0]    far_cm  = urd_pkg::FAR_RST;
  logic [urd_pkg::CM_W-1:0]    mid_cm  = urd_pkg::MID_RST;
  logic [urd_pkg::CM_W-1:0]    near_cm = urd_pkg::NEAR_RST;
  logic [urd_pkg::DIGIT_W-1:0] digits_now [SCAN_DIGITS];
  logic [1:0]                  scan_pos = '0;
  logic                        enable_now = 1'b1;
  logic [urd_pkg::LOCK_W-1:0]  lock_ms = urd_pkg::LOCK_SAT;
  logic [urd_pkg::ZONE_W-1:0]  zone_now = urd_pkg::ZONE_FAR;
  logic [urd_pkg::CM_W-1:0]    cm_now = '0;

  urd_pkg::in_item_t  pend_q [$];
  urd_pkg::out_item_t display_expect_q [$];

  bit steady = 1'b0;
  int mismatches = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int measured_cnt = 0;
  int ignored_cnt = 0;
  int scan_cnt = 0;
  int toggle_cnt = 0;
  int cfg_writes = 0;

  initial begin
    for (int i = 0; i < SCAN_DIGITS; i++) digits_now[i] = '0;
  end

  ultrasonic_range_display #(
    .NUM_DIGITS(urd_pkg::NUM_DIGITS_DEF),
    .LOCKOUT_MS(urd_pkg::LOCKOUT_MS_DEF)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // Lit segments a..g for one decimal digit
  function automatic logic [urd_pkg::SEG_W-1:0] lit_segments(
      input logic [urd_pkg::DIGIT_W-1:0] d);
    case (d)
      4'd0: return 7'h3F;
      4'd1: return 7'h06;
      4'd2: return 7'h5B;
      4'd3: return 7'h4F;
      4'd4: return 7'h66;
      4'd5: return 7'h6D;
      4'd6: return 7'h7D;
      4'd7: return 7'h07;
      4'd8: return 7'h7F;
      4'd9: return 7'h6F;
      default: return 7'h00;
    endcase
  endfunction

  // Advance the shadow state by one request and queue the result it produces
  task automatic predict_display(input urd_pkg::in_item_t item);
    urd_pkg::out_item_t res;
    logic [31:0]        prod;
    int                 v;
    res = '0;
    res.segments_n = urd_pkg::SEG_BLANK_N;
    res.digit_enable = '0;
    case (item.req_type)
      urd_pkg::REQ_MEASURE: begin
        if (enable_now) begin
          prod = item.echo_us * urd_pkg::CM_SCALE_Q16;
          cm_now = (prod[31:16] > urd_pkg::MAX_CM) ? urd_pkg::MAX_CM
                                                   : prod[urd_pkg::CM_W+15:16];
          v = int'(cm_now);
          for (int i = SCAN_DIGITS - 1; i >= 0; i--) begin
            digits_now[i] = urd_pkg::DIGIT_W'(v % 10);
            v = v / 10;
          end
          // Zones are decided on the full-precision product
          if (prod > {2'b00, far_cm, 16'h0000}) zone_now = urd_pkg::ZONE_FAR;
          else if (prod > {2'b00, mid_cm, 16'h0000}) zone_now = urd_pkg::ZONE_MID;
          else if (prod > {2'b00, near_cm, 16'h0000}) zone_now = urd_pkg::ZONE_NEAR;
          else zone_now = urd_pkg::ZONE_CRIT;
          res.tone_start = 1'b1;
          case (zone_now)
            urd_pkg::ZONE_FAR:  res.tone_hz = 10'd150;
            urd_pkg::ZONE_MID:  res.tone_hz = 10'd300;
            urd_pkg::ZONE_NEAR: res.tone_hz = 10'd400;
            default:            res.tone_hz = 10'd523;
          endcase
          measured_cnt++;
        end else begin
          ignored_cnt++;
        end
      end
      urd_pkg::REQ_SCAN: begin
        res.segments_n = ~lit_segments(digits_now[scan_pos]);
        res.digit_enable = 4'b0001 << scan_pos;
        scan_pos = scan_pos + 2'd1;
        scan_cnt++;
      end
      urd_pkg::REQ_BUTTON: begin
        if (lock_ms > urd_pkg::LOCKOUT_MS_DEF) begin
          enable_now = ~enable_now;
          lock_ms = '0;
          toggle_cnt++;
        end
      end
      default: begin
        if (lock_ms != urd_pkg::LOCK_SAT) lock_ms = lock_ms + 8'd1;
      end
    endcase
    case (zone_now)
      urd_pkg::ZONE_FAR: res.led_lines = urd_pkg::LED_GREEN;
      urd_pkg::ZONE_MID: res.led_lines = urd_pkg::LED_YELLOW;
      default:           res.led_lines = urd_pkg::LED_RED;
    endcase
    res.zone = zone_now;
    res.distance_cm = cm_now;
    res.enabled = enable_now;
    display_expect_q.push_back(res);
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  task automatic cmp_field(input string name, input logic [15:0] got,
                           input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                results_seen, name, got, want));
  endtask

  task automatic check_display(input urd_pkg::out_item_t got);
    urd_pkg::out_item_t want;
    if (display_expect_q.size() == 0) begin
      report_mismatch($sformatf("result 0x%0h arrived with nothing pending", got));
      return;
    end
    want = display_expect_q.pop_front();
    cmp_field("segments_n", 16'(got.segments_n), 16'(want.segments_n));
    cmp_field("digit_enable", 16'(got.digit_enable), 16'(want.digit_enable));
    cmp_field("led_lines", 16'(got.led_lines), 16'(want.led_lines));
    cmp_field("zone", 16'(got.zone), 16'(want.zone));
    cmp_field("tone_start", 16'(got.tone_start), 16'(want.tone_start));
    cmp_field("tone_hz", 16'(got.tone_hz), 16'(want.tone_hz));
    cmp_field("distance_cm", 16'(got.distance_cm), 16'(want.distance_cm));
    cmp_field("enabled", 16'(got.enabled), 16'(want.enabled));
    results_seen++;
  endtask

  function automatic urd_pkg::in_item_t mk_item(input logic [urd_pkg::REQ_W-1:0] req,
                                                input logic [urd_pkg::ECHO_W-1:0] echo);
    urd_pkg::in_item_t it;
    it.req_type = req;
    it.echo_us = echo;
    return it;
  endfunction

  // Smallest echo whose product lies above the threshold, moved by offset
  function automatic logic [urd_pkg::ECHO_W-1:0] echo_edge(
      input logic [urd_pkg::CM_W-1:0] thr, input int offset);
    longint e;
    e = (longint'(thr) << 16) / longint'(urd_pkg::CM_SCALE_Q16);
    e = e + 1 + offset;
    if (e < 0) e = 0;
    if (e > longint'(ECHO_TOP)) e = longint'(ECHO_TOP);
    return e[urd_pkg::ECHO_W-1:0];
  endfunction

  // Fill the pending queue with a random mix of requests
  task automatic queue_traffic(input int n_items);
    int                           cnt;
    int                           r;
    int                           pick;
    logic [urd_pkg::ECHO_W-1:0]   echo;
    logic [urd_pkg::CM_W-1:0]     thr;
    cnt = 0;
    while (cnt < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        // Measurement: near a zone boundary, else wide, short or extreme echoes
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          case ($urandom_range(0, 2))
            0:       thr = far_cm;
            1:       thr = mid_cm;
            default: thr = near_cm;
          endcase
          echo = echo_edge(thr, int'($urandom_range(0, 3)) - 2);
        end else if (pick < 70) begin
          echo = urd_pkg::ECHO_W'($urandom);
        end else if (pick < 90) begin
          echo = urd_pkg::ECHO_W'($urandom_range(0, 4095));
        end else begin
          case ($urandom_range(0, 2))
            0:       echo = '0;
            1:       echo = 16'd1;
            default: echo = ECHO_TOP;
          endcase
        end
        pend_q.push_back(mk_item(urd_pkg::REQ_MEASURE, echo));
        cnt++;
      end else if (r < 70) begin
        pend_q.push_back(mk_item(urd_pkg::REQ_SCAN, urd_pkg::ECHO_W'($urandom)));
        cnt++;
      end else if (r < 80) begin
        // Full sweep of the display
        repeat (SCAN_DIGITS)
          pend_q.push_back(mk_item(urd_pkg::REQ_SCAN, urd_pkg::ECHO_W'($urandom)));
        cnt += SCAN_DIGITS;
      end else if (r < 92) begin
        pick = $urandom_range(1, 3);
        repeat (pick)
          pend_q.push_back(mk_item(urd_pkg::REQ_MS_TICK, urd_pkg::ECHO_W'($urandom)));
        cnt += pick;
      end else begin
        pend_q.push_back(mk_item(urd_pkg::REQ_BUTTON, urd_pkg::ECHO_W'($urandom)));
        cnt++;
      end
    end
  endtask

  // Hold until nothing is in flight, then let the pipeline settle
  task automatic wait_drained();
    @(negedge clk);
    while (pend_q.size() != 0 || in_valid || display_expect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [urd_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [urd_pkg::CM_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      urd_pkg::CFG_FAR:  far_cm = val;
      urd_pkg::CFG_MID:  mid_cm = val;
      urd_pkg::CFG_NEAR: near_cm = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic write_ordered_thresholds();
    logic [urd_pkg::CM_W-1:0] lo;
    logic [urd_pkg::CM_W-1:0] md;
    lo = 14'($urandom_range(0, 400));
    md = lo + 14'($urandom_range(1, 400));
    write_threshold(urd_pkg::CFG_FAR, md + 14'($urandom_range(1, 400)));
    write_threshold(urd_pkg::CFG_MID, md);
    write_threshold(urd_pkg::CFG_NEAR, lo);
  endtask

  // Driver: predict on each input transfer, then offer the next pending item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_display(in_data);
      if (!in_valid || in_ready) begin
        if (pend_q.size() != 0 && (steady || $urandom_range(0, 99) >= 21)) begin
          in_valid <= 1'b1;
          in_data  <= pend_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output transfer and stall the result channel at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_display(out_data);
    out_ready <= steady || ($urandom_range(0, 99) >= 21);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d results pending",
               cycle_count, display_expect_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset display, timeout, maximum echo, each zone boundary
    pend_q.push_back(mk_item(urd_pkg::REQ_SCAN, '0));
    pend_q.push_back(mk_item(urd_pkg::REQ_MEASURE, '0));
    pend_q.push_back(mk_item(urd_pkg::REQ_MEASURE, ECHO_TOP));
    pend_q.push_back(mk_item(urd_pkg::REQ_MEASURE, echo_edge(urd_pkg::FAR_RST, 0)));
    pend_q.push_back(mk_item(urd_pkg::REQ_MEASURE, echo_edge(urd_pkg::FAR_RST, -1)));
    pend_q.push_back(mk_item(urd_pkg::REQ_MEASURE, echo_edge(urd_pkg::MID_RST, 0)));
    pend_q.push_back(mk_item(urd_pkg::REQ_MEASURE, echo_edge(urd_pkg::MID_RST, -1)));
    pend_q.push_back(mk_item(urd_pkg::REQ_MEASURE, echo_edge(urd_pkg::NEAR_RST, 0)));
    pend_q.push_back(mk_item(urd_pkg::REQ_MEASURE, echo_edge(urd_pkg::NEAR_RST, -1)));
    pend_q.push_back(mk_item(urd_pkg::REQ_MEASURE, 16'd58049));
    // Sweep all digits and wrap around
    repeat (SCAN_DIGITS + 1) pend_q.push_back(mk_item(urd_pkg::REQ_SCAN, '0));
    // Tick at saturation, toggle off, ignored measurement, locked-out press
    pend_q.push_back(mk_item(urd_pkg::REQ_MS_TICK, '0));
    pend_q.push_back(mk_item(urd_pkg::REQ_BUTTON, '0));
    pend_q.push_back(mk_item(urd_pkg::REQ_MEASURE, 16'd12345));
    pend_q.push_back(mk_item(urd_pkg::REQ_SCAN, '0));
    pend_q.push_back(mk_item(urd_pkg::REQ_BUTTON, '0));
    pend_q.push_back(mk_item(urd_pkg::REQ_MS_TICK, '0));
    // Count the lockout up to its limit: press at the limit is refused, one tick later it toggles
    repeat (urd_pkg::LOCKOUT_MS_DEF - 1)
      pend_q.push_back(mk_item(urd_pkg::REQ_MS_TICK, urd_pkg::ECHO_W'($urandom)));
    pend_q.push_back(mk_item(urd_pkg::REQ_BUTTON, urd_pkg::ECHO_W'($urandom)));
    pend_q.push_back(mk_item(urd_pkg::REQ_MEASURE, urd_pkg::ECHO_W'($urandom)));
    pend_q.push_back(mk_item(urd_pkg::REQ_MS_TICK, urd_pkg::ECHO_W'($urandom)));
    pend_q.push_back(mk_item(urd_pkg::REQ_BUTTON, urd_pkg::ECHO_W'($urandom)));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        wait_drained();
        case (ph)
          1: begin
            write_ordered_thresholds();
            write_threshold(CFG_SPARE, urd_pkg::CM_W'($urandom));
          end
          2: begin
            write_threshold(urd_pkg::CFG_FAR, '0);
            write_threshold(urd_pkg::CFG_MID, '0);
            write_threshold(urd_pkg::CFG_NEAR, '0);
          end
          3: begin
            write_threshold(urd_pkg::CFG_FAR, THR_TOP);
            write_threshold(urd_pkg::CFG_MID, urd_pkg::MAX_CM);
            write_threshold(urd_pkg::CFG_NEAR, THR_TOP);
          end
          4: begin
            write_threshold(urd_pkg::CFG_FAR, urd_pkg::CM_W'($urandom_range(0, 1200)));
            write_threshold(urd_pkg::CFG_MID, urd_pkg::CM_W'($urandom_range(0, 1200)));
            write_threshold(urd_pkg::CFG_NEAR, urd_pkg::CM_W'($urandom_range(0, 1200)));
          end
          default: begin
            write_ordered_thresholds();
            steady = 1'b1;
          end
        endcase
        @(negedge clk);
      end
      queue_traffic(PHASE_ITEMS);
    end

    wait_drained();
    if (display_expect_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", display_expect_q.size()));

    $display("checked %0d results: %0d measurements (%0d while disabled), %0d scans,",
             results_seen, measured_cnt, ignored_cnt, scan_cnt);
    $display("%0d enable toggles, %0d threshold writes over %0d settings, %0d errors",
             toggle_cnt, cfg_writes, NUM_PHASES, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
